// ===== hw/rtl/olie_pkg.sv =====
package olie_pkg;

  localparam int DEF_LIST_DEPTH = 32;
  localparam int DATA_W         = 32;
  localparam int LEN_W          = 7;

  // command codes
  localparam logic [1:0] CMD_HEAD  = 2'd0;
  localparam logic [1:0] CMD_TAIL  = 2'd1;
  localparam logic [1:0] CMD_AFTER = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SEARCH,
    S_LINK2,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/ordered_list_insert_engine.sv =====
// Insert at head or tail: S_IDLE takes the request, S_EMIT loads the result, plus output wait.
// Insert after key: S_SEARCH walks node by node, then S_LINK2 when the node is mid-list, then S_EMIT.
// Readout: one node per cycle from the value memory read port while the result slot is free.
// One request in flight; a new request is taken while the last result waits.
// Synchronous active-low reset empties the list; node memories are not cleared.
module ordered_list_insert_engine #(
  parameter int LIST_DEPTH = olie_pkg::DEF_LIST_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic signed [olie_pkg::DATA_W-1:0]  in_value,
  input  logic signed [olie_pkg::DATA_W-1:0]  in_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [olie_pkg::DATA_W-1:0]  out_item,
  output logic                                out_last,
  output logic [olie_pkg::LEN_W-1:0]          out_length
);

  localparam int IW = $clog2(LIST_DEPTH);      // node index width
  localparam int CW = $clog2(LIST_DEPTH + 1);  // node count width
  localparam int DW = olie_pkg::DATA_W;

  olie_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt;     // node whose data sits on the read port
  logic [CW-1:0] idx_r, idx_nxt;     // position of cur_r in the list
  logic [DW-1:0] value_r, value_nxt;
  logic [DW-1:0] key_r, key_nxt;
  logic [1:0]    st_r, st_nxt;

  // result register
  logic          out_valid_r;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [DW-1:0] out_item_r, out_item_nxt;
  logic          out_last_r, out_last_nxt;
  logic [olie_pkg::LEN_W-1:0] out_length_r, out_length_nxt;
  logic          out_load;

  // memory ports
  logic          val_we, lnk_we;
  logic [IW-1:0] val_waddr, lnk_waddr, rd_addr;
  logic [DW-1:0] val_wdata, val_rdata;
  logic [IW-1:0] lnk_wdata, lnk_rdata;

  logic [IW-1:0] new_idx;
  logic          is_empty, is_full, last_node, slot_free;

  assign new_idx   = count_r[IW-1:0];    // nodes are allocated in order
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(LIST_DEPTH));
  assign last_node = ((idx_r + CW'(1)) == count_r);
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready   = (state_r == olie_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;
  assign out_length = out_length_r;

  olie_ram #(.WIDTH(DW), .DEPTH(LIST_DEPTH)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  olie_ram #(.WIDTH(IW), .DEPTH(LIST_DEPTH)) u_links (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (rd_addr),
    .rdata (lnk_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    key_nxt        = key_r;
    st_nxt         = st_r;
    val_we         = 1'b0;
    val_waddr      = new_idx;
    val_wdata      = value_r;
    lnk_we         = 1'b0;
    lnk_waddr      = new_idx;
    lnk_wdata      = '0;
    rd_addr        = cur_r;  // re-read holds the data during a stall
    out_load       = 1'b0;
    out_status_nxt = st_r;
    out_item_nxt   = '0;
    out_last_nxt   = 1'b1;
    out_length_nxt = olie_pkg::LEN_W'(count_r);

    case (state_r)
      olie_pkg::S_IDLE: begin
        // head is read on every idle cycle so a walk starts with data in hand
        rd_addr = head_r;
        if (in_valid) begin
          cur_nxt   = head_r;
          idx_nxt   = '0;
          value_nxt = in_value;
          key_nxt   = in_key;
          st_nxt    = olie_pkg::ST_OK;
          state_nxt = olie_pkg::S_EMIT;
          if (in_cmd == olie_pkg::CMD_READ) begin
            if (is_empty) begin
              st_nxt = olie_pkg::ST_EMPTY;
            end else begin
              state_nxt = olie_pkg::S_WALK;
            end
          end else if (is_full) begin
            st_nxt = olie_pkg::ST_FULL;
          end else if (in_cmd == olie_pkg::CMD_HEAD) begin
            val_we    = 1'b1;
            val_wdata = in_value;
            lnk_we    = 1'b1;
            lnk_wdata = is_empty ? '0 : head_r;
            head_nxt  = new_idx;
            if (is_empty) begin
              tail_nxt = new_idx;
            end
            count_nxt = count_r + CW'(1);
          end else if (in_cmd == olie_pkg::CMD_TAIL) begin
            val_we    = 1'b1;
            val_wdata = in_value;
            lnk_we    = 1'b1;
            if (is_empty) begin
              head_nxt = new_idx;
            end else begin
              // hook the new node behind the old tail
              lnk_waddr = tail_r;
              lnk_wdata = new_idx;
            end
            tail_nxt  = new_idx;
            count_nxt = count_r + CW'(1);
          end else begin
            if (is_empty) begin
              st_nxt = olie_pkg::ST_NOT_FOUND;
            end else begin
              state_nxt = olie_pkg::S_SEARCH;
            end
          end
        end
      end

      olie_pkg::S_WALK: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = olie_pkg::ST_OK;
          out_item_nxt   = val_rdata;
          out_last_nxt   = last_node;
          if (last_node) begin
            state_nxt = olie_pkg::S_IDLE;
          end else begin
            rd_addr = lnk_rdata;
            cur_nxt = lnk_rdata;
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      olie_pkg::S_SEARCH: begin
        if (val_rdata == key_r) begin
          val_we = 1'b1;
          lnk_we = 1'b1;
          if (cur_r == tail_r) begin
            lnk_waddr = cur_r;
            lnk_wdata = new_idx;
            tail_nxt  = new_idx;
            count_nxt = count_r + CW'(1);
            state_nxt = olie_pkg::S_EMIT;
          end else begin
            // new node takes over the match's successor; relink in S_LINK2
            lnk_waddr = new_idx;
            lnk_wdata = lnk_rdata;
            state_nxt = olie_pkg::S_LINK2;
          end
        end else if (last_node) begin
          st_nxt    = olie_pkg::ST_NOT_FOUND;
          state_nxt = olie_pkg::S_EMIT;
        end else begin
          rd_addr = lnk_rdata;
          cur_nxt = lnk_rdata;
          idx_nxt = idx_r + CW'(1);
        end
      end

      olie_pkg::S_LINK2: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_r;
        lnk_wdata = new_idx;
        count_nxt = count_r + CW'(1);
        state_nxt = olie_pkg::S_EMIT;
      end

      olie_pkg::S_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = olie_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olie_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olie_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    key_r   <= key_nxt;
    st_r    <= st_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_item_r   <= out_item_nxt;
      out_last_r   <= out_last_nxt;
      out_length_r <= out_length_nxt;
    end
  end

endmodule

// ===== hw/rtl/olie_ram.sv =====
module olie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/olie_chk.sv =====
module olie_chk #(
  parameter int LIST_DEPTH = olie_pkg::DEF_LIST_DEPTH
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic signed [olie_pkg::DATA_W-1:0] out_item,
  input logic                               out_last,
  input logic [olie_pkg::LEN_W-1:0]         out_length
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(out_status)
      && $stable(out_last) && $stable(out_length))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // error results carry no item and close the run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != olie_pkg::ST_OK |-> out_last && out_item == '0)
    else $error("error result not final or item nonzero");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length <= olie_pkg::LEN_W'(LIST_DEPTH))
    else $error("length above list depth");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == olie_pkg::ST_EMPTY |-> out_length == '0)
    else $error("empty status with nonzero length");

endmodule

bind ordered_list_insert_engine olie_chk #(.LIST_DEPTH(LIST_DEPTH)) u_olie_chk (.*);
